[src/inr_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// inr_pkg
// Widths, calendar constants and reciprocal constants shared by the
// interval normalizer pipeline.
// ============================================================================
package inr_pkg;

   // Field widths at the ports.
   localparam int IN_W   = 24;
   localparam int YR_W   = 26;
   localparam int MO_W   = 5;
   localparam int DY_W   = 6;
   localparam int TS_W   = 18;
   localparam int TH_W   = 5;
   localparam int TM_W   = 6;
   localparam int TSEC_W = 6;

   // Pipeline depth and the first stage of each unit.
   localparam int NSTAGE    = 10;
   localparam int STG_MERGE = 3;
   localparam int STG_CARRY = 5;

   // Internal widths, sized for the worst case of every input pattern.
   localparam int TSUM_W = 36;   // seconds + 60 * minutes + 3600 * hours
   localparam int TMAG_W = 35;   // magnitude of that sum
   localparam int TABS_W = 17;   // magnitude of time within one day
   localparam int DQ1_W  = 19;   // whole days taken out of the time
   localparam int DSUM_W = 28;   // days after weeks and time are merged
   localparam int DMIX_W = 33;   // days after months and years are merged
   localparam int DMAG_W = 32;   // magnitude of those days
   localparam int KQ_W   = 28;   // months carried out of the days
   localparam int DREM_W = 5;    // remainder of a month, 0 to 29
   localparam int REM2_W = 6;    // remainder before its last correction
   localparam int MMAG_W = 28;   // magnitude of months before the year fold
   localparam int MQ_W   = 25;   // years carried out of the months
   localparam int MREM_W = 4;    // months left, 0 to 11
   localparam int MT_W   = 11;   // whole minutes in one day

   // Calendar constants.
   localparam int SECS_PER_DAY    = 86400;
   localparam int DAYS_PER_MONTH  = 30;
   localparam int MONTHS_PER_YEAR = 12;
   localparam int SECS_PER_MIN    = 60;

   // Division by 86400 is a shift by 7 and a multiply by the reciprocal of
   // 675; the estimate is low by at most one and gets corrected afterwards.
   localparam int          DAY_SHIFT       = 7;
   localparam int          DAY_RECIP_W     = 29;
   localparam int          DAY_RECIP_SHIFT = 38;
   localparam logic [28:0] DAY_RECIP       = 29'd407226528;

   // Division by 30 is a shift by 1 and a multiply by the reciprocal of 15.
   localparam int          DQ_RECIP_W     = 32;
   localparam int          DQ_RECIP_SHIFT = 35;
   localparam logic [31:0] DQ_RECIP       = 32'd2290649224;

   // Division by 12 is a shift by 2 and a multiply by the reciprocal of 3.
   localparam int          MQ_RECIP_W     = 27;
   localparam int          MQ_RECIP_SHIFT = 28;
   localparam logic [26:0] MQ_RECIP       = 27'd89478485;

   // Division by 60 of values below 2^17: shift by 2, then a rounded-up
   // reciprocal of 15 that is exact over that range.
   localparam int          TQ_RECIP_W     = 17;
   localparam int          TQ_SHIFT       = 20;
   localparam logic [16:0] TQ_RECIP       = 17'd69906;

   typedef logic signed [IN_W-1:0] field_type;

endpackage

[src/inr_day_split.sv]
`timescale 1ns / 1ps
// ============================================================================
// inr_day_split
// Folds hours, minutes and seconds into one time in seconds, moves whole
// days out of a time longer than one day and adds the weeks to the days.
// ============================================================================
module inr_day_split (
   input  logic                            clock,
   input  logic [2:0]                      adv,
   input  inr_pkg::field_type              years_in,
   input  inr_pkg::field_type              months_in,
   input  inr_pkg::field_type              weeks_in,
   input  inr_pkg::field_type              days_in,
   input  inr_pkg::field_type              hours_in,
   input  inr_pkg::field_type              minutes_in,
   input  inr_pkg::field_type              seconds_in,
   output logic signed [inr_pkg::TS_W-1:0]   t_out,
   output logic signed [inr_pkg::DSUM_W-1:0] dy_out,
   output inr_pkg::field_type              mo_out,
   output inr_pkg::field_type              yr_out
);
   import inr_pkg::*;

   localparam int BX_W    = TMAG_W - DAY_SHIFT;
   localparam int BPROD_W = BX_W + DAY_RECIP_W;

   // Stage 1: raw time and days.
   logic signed [TSUM_W-1:0] se_x, mi_x, hr_x;
   logic signed [DSUM_W-1:0] dy_x, wk_x;
   logic signed [TSUM_W-1:0] s1_t_in, s1_t_ff;
   logic signed [DSUM_W-1:0] s1_dy_in, s1_dy_ff;
   field_type                s1_mo_ff, s1_yr_ff;

   // Stage 2: magnitude of the time and the estimated day count.
   logic [TSUM_W-1:0]  s2_abs;
   logic [BX_W-1:0]    s2_x;
   logic [BPROD_W-1:0] s2_prod;
   logic [TMAG_W-1:0]  s2_at_in, s2_at_ff;
   logic [DQ1_W-1:0]   s2_q_in, s2_q_ff;
   logic               s2_neg_in, s2_neg_ff;
   logic               s2_big_in, s2_big_ff;
   logic signed [DSUM_W-1:0] s2_dy_ff;
   field_type                s2_mo_ff, s2_yr_ff;

   // Stage 3: corrected day count, remaining time and merged days.
   logic [TSUM_W-1:0]        s3_sub;
   logic [TS_W-1:0]          s3_rem;
   logic                     s3_fix;
   logic [DQ1_W-1:0]         s3_q;
   logic [TABS_W-1:0]        s3_r;
   logic signed [DSUM_W-1:0] s3_qs;
   logic signed [TS_W-1:0]   s3_t_in, s3_t_ff;
   logic signed [DSUM_W-1:0] s3_dy_in, s3_dy_ff;
   field_type                s3_mo_ff, s3_yr_ff;

   always_comb begin
      se_x = TSUM_W'(seconds_in);
      mi_x = TSUM_W'(minutes_in);
      hr_x = TSUM_W'(hours_in);
      dy_x = DSUM_W'(days_in);
      wk_x = DSUM_W'(weeks_in);
      // 60 = 64 - 4 and 3600 = 4096 - 512 + 16
      s1_t_in  = se_x + (mi_x <<< 6) - (mi_x <<< 2)
                 + (hr_x <<< 12) - (hr_x <<< 9) + (hr_x <<< 4);
      s1_dy_in = dy_x + (wk_x <<< 3) - wk_x;
   end

   always_comb begin
      s2_neg_in = s1_t_ff[TSUM_W-1];
      s2_abs    = s2_neg_in ? -s1_t_ff : s1_t_ff;
      s2_at_in  = s2_abs[TMAG_W-1:0];
      s2_x      = s2_at_in[TMAG_W-1:DAY_SHIFT];
      s2_prod   = BPROD_W'(s2_x) * BPROD_W'(DAY_RECIP);
      s2_q_in   = s2_prod[DAY_RECIP_SHIFT +: DQ1_W];
      // A time of exactly one day stays as time.
      s2_big_in = s2_at_in > TMAG_W'(SECS_PER_DAY);
   end

   always_comb begin
      s3_sub = TSUM_W'(s2_at_ff) - TSUM_W'(s2_q_ff) * TSUM_W'(SECS_PER_DAY);
      s3_rem = s3_sub[TS_W-1:0];
      s3_fix = s3_rem >= TS_W'(SECS_PER_DAY);
      if (!s2_big_ff) begin
         s3_q = '0;
         s3_r = s2_at_ff[TABS_W-1:0];
      end else if (s3_fix) begin
         s3_q = s2_q_ff + 1'b1;
         s3_r = TABS_W'(s3_rem - TS_W'(SECS_PER_DAY));
      end else begin
         s3_q = s2_q_ff;
         s3_r = s3_rem[TABS_W-1:0];
      end
      s3_qs    = $signed(DSUM_W'(s3_q));
      s3_t_in  = s2_neg_ff ? -$signed(TS_W'(s3_r)) : $signed(TS_W'(s3_r));
      s3_dy_in = s2_neg_ff ? s2_dy_ff - s3_qs : s2_dy_ff + s3_qs;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_t_ff  <= s1_t_in;
         s1_dy_ff <= s1_dy_in;
         s1_mo_ff <= months_in;
         s1_yr_ff <= years_in;
      end
      if (adv[1]) begin
         s2_at_ff  <= s2_at_in;
         s2_q_ff   <= s2_q_in;
         s2_neg_ff <= s2_neg_in;
         s2_big_ff <= s2_big_in;
         s2_dy_ff  <= s1_dy_ff;
         s2_mo_ff  <= s1_mo_ff;
         s2_yr_ff  <= s1_yr_ff;
      end
      if (adv[2]) begin
         s3_t_ff  <= s3_t_in;
         s3_dy_ff <= s3_dy_in;
         s3_mo_ff <= s2_mo_ff;
         s3_yr_ff <= s2_yr_ff;
      end
   end

   assign t_out  = s3_t_ff;
   assign dy_out = s3_dy_ff;
   assign mo_out = s3_mo_ff;
   assign yr_out = s3_yr_ff;

endmodule

[src/inr_sign_merge.sv]
`timescale 1ns / 1ps
// ============================================================================
// inr_sign_merge
// Detects mixed signs among time, days, months and years, turns months and
// years into days in that case and lets the time borrow one day.
// ============================================================================
module inr_sign_merge (
   input  logic                              clock,
   input  logic [1:0]                        adv,
   input  logic signed [inr_pkg::TS_W-1:0]   t_in,
   input  logic signed [inr_pkg::DSUM_W-1:0] dy_in,
   input  inr_pkg::field_type                mo_in,
   input  inr_pkg::field_type                yr_in,
   output logic signed [inr_pkg::TS_W-1:0]   t_out,
   output logic [inr_pkg::DMAG_W-1:0]        dmag_out,
   output logic                              dneg_out,
   output inr_pkg::field_type                mo_out,
   output inr_pkg::field_type                yr_out
);
   import inr_pkg::*;

   // Stage 1: sign check and day merge.
   logic t_pos, t_neg, d_pos, d_neg, m_pos, m_neg, y_pos, y_neg;
   logic signed [DMIX_W-1:0] dy_x, mo_x, yr_x;
   logic                     s1_mixed_in, s1_mixed_ff;
   logic signed [DMIX_W-1:0] s1_dy_in, s1_dy_ff;
   field_type                s1_mo_in, s1_mo_ff, s1_yr_in, s1_yr_ff;
   logic signed [TS_W-1:0]   s1_t_ff;

   // Stage 2: one-day borrow and day magnitude.
   logic              s2_tneg, s2_tpos, s2_dneg, s2_dpos;
   logic              s2_take, s2_give;
   logic [DMIX_W-1:0] s2_dabs;
   logic [DMAG_W-1:0] s2_dmag_in, s2_dmag_ff;
   logic signed [TS_W-1:0] s2_t_in, s2_t_ff;
   logic              s2_dneg_ff;
   field_type         s2_mo_ff, s2_yr_ff;

   always_comb begin
      t_neg = t_in[TS_W-1];
      t_pos = !t_neg && (t_in != '0);
      d_neg = dy_in[DSUM_W-1];
      d_pos = !d_neg && (dy_in != '0);
      m_neg = mo_in[IN_W-1];
      m_pos = !m_neg && (mo_in != '0);
      y_neg = yr_in[IN_W-1];
      y_pos = !y_neg && (yr_in != '0);
      s1_mixed_in = (t_pos || d_pos || m_pos || y_pos)
                    && (t_neg || d_neg || m_neg || y_neg);
      dy_x = DMIX_W'(dy_in);
      mo_x = DMIX_W'(mo_in);
      yr_x = DMIX_W'(yr_in);
      // 30 = 32 - 2 and 360 = 512 - 128 - 32 + 8
      if (s1_mixed_in) begin
         s1_dy_in = dy_x + (mo_x <<< 5) - (mo_x <<< 1)
                    + (yr_x <<< 9) - (yr_x <<< 7) - (yr_x <<< 5) + (yr_x <<< 3);
         s1_mo_in = '0;
         s1_yr_in = '0;
      end else begin
         s1_dy_in = dy_x;
         s1_mo_in = mo_in;
         s1_yr_in = yr_in;
      end
   end

   always_comb begin
      s2_tneg = s1_t_ff[TS_W-1];
      s2_tpos = !s2_tneg && (s1_t_ff != '0);
      s2_dneg = s1_dy_ff[DMIX_W-1];
      s2_dpos = !s2_dneg && (s1_dy_ff != '0);
      // The time takes one day from days of the other sign.
      s2_take = s1_mixed_ff && s2_tneg && s2_dpos;
      s2_give = s1_mixed_ff && s2_tpos && s2_dneg;
      s2_dabs = s2_dneg ? -s1_dy_ff : s1_dy_ff;
      s2_dmag_in = s2_dabs[DMAG_W-1:0] - DMAG_W'(s2_take || s2_give);
      if (s2_take) begin
         s2_t_in = s1_t_ff + TS_W'(SECS_PER_DAY);
      end else if (s2_give) begin
         s2_t_in = s1_t_ff - TS_W'(SECS_PER_DAY);
      end else begin
         s2_t_in = s1_t_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_mixed_ff <= s1_mixed_in;
         s1_dy_ff    <= s1_dy_in;
         s1_mo_ff    <= s1_mo_in;
         s1_yr_ff    <= s1_yr_in;
         s1_t_ff     <= t_in;
      end
      if (adv[1]) begin
         s2_t_ff    <= s2_t_in;
         s2_dmag_ff <= s2_dmag_in;
         s2_dneg_ff <= s2_dneg;
         s2_mo_ff   <= s1_mo_ff;
         s2_yr_ff   <= s1_yr_ff;
      end
   end

   assign t_out    = s2_t_ff;
   assign dmag_out = s2_dmag_ff;
   assign dneg_out = s2_dneg_ff;
   assign mo_out   = s2_mo_ff;
   assign yr_out   = s2_yr_ff;

endmodule

[src/inr_carry.sv]
`timescale 1ns / 1ps
// ============================================================================
// inr_carry
// Carries days into months, 30 at a time, until at most 30 days are left,
// then folds months into years, 12 at a time.
// ============================================================================
module inr_carry (
   input  logic                             clock,
   input  logic [4:0]                       adv,
   input  logic [inr_pkg::DMAG_W-1:0]       dmag_in,
   input  logic                             dneg_in,
   input  inr_pkg::field_type               mo_in,
   input  inr_pkg::field_type               yr_in,
   output logic signed [inr_pkg::YR_W-1:0]  years,
   output logic signed [inr_pkg::MO_W-1:0]  months,
   output logic signed [inr_pkg::DY_W-1:0]  days
);
   import inr_pkg::*;

   localparam int DX_W    = DMAG_W - 1;
   localparam int DPROD_W = DX_W + DQ_RECIP_W;
   localparam int MX_W    = MMAG_W - 2;
   localparam int MPROD_W = MX_W + MQ_RECIP_W;

   // Stage 1: estimate of (days - 1) / 30.
   logic [DMAG_W-1:0]  s1_dm1_in, s1_dm1_ff;
   logic [DPROD_W-1:0] s1_prod;
   logic [KQ_W-1:0]    s1_q_in, s1_q_ff;
   logic               s1_dnz_ff, s1_dneg_ff;
   field_type          s1_mo_ff, s1_yr_ff;

   // Stage 2: corrected carry and remaining days.
   logic [DMAG_W-1:0] s2_sub;
   logic [REM2_W-1:0] s2_rem;
   logic              s2_fix;
   logic [KQ_W-1:0]   s2_k_in, s2_k_ff;
   logic [DREM_W-1:0] s2_r_in, s2_r_ff;
   logic              s2_dnz_ff, s2_dneg_ff;
   field_type         s2_mo_ff, s2_yr_ff;

   // Stage 3: signed days and month magnitude.
   logic [DY_W-1:0]          s3_dval;
   logic [IN_W-1:0]          s3_mabs;
   logic signed [DY_W-1:0]   s3_days_in, s3_days_ff;
   logic [MMAG_W-1:0]        s3_mmag_in, s3_mmag_ff;
   logic                     s3_mneg_in, s3_mneg_ff;
   field_type                s3_yr_ff;

   // Stage 4: estimate of months / 12.
   logic [MPROD_W-1:0]     s4_prod;
   logic [MQ_W-1:0]        s4_q_in, s4_q_ff;
   logic [MMAG_W-1:0]      s4_mmag_ff;
   logic                   s4_mneg_ff;
   logic signed [DY_W-1:0] s4_days_ff;
   field_type              s4_yr_ff;

   // Stage 5: corrected year carry and final fields.
   logic [MMAG_W-1:0]        s5_sub;
   logic [DREM_W-1:0]        s5_rem;
   logic                     s5_fix;
   logic [MQ_W-1:0]          s5_q;
   logic [MREM_W-1:0]        s5_r;
   logic signed [YR_W-1:0]   s5_qs;
   logic signed [YR_W-1:0]   s5_yr_in, s5_yr_ff;
   logic signed [MO_W-1:0]   s5_mo_in, s5_mo_ff;
   logic signed [DY_W-1:0]   s5_days_ff;

   always_comb begin
      s1_dm1_in = dmag_in - 1'b1;
      s1_prod   = DPROD_W'(s1_dm1_in[DMAG_W-1:1]) * DPROD_W'(DQ_RECIP);
      s1_q_in   = s1_prod[DQ_RECIP_SHIFT +: KQ_W];
   end

   always_comb begin
      s2_sub = s1_dm1_ff - DMAG_W'(s1_q_ff) * DMAG_W'(DAYS_PER_MONTH);
      s2_rem = s2_sub[REM2_W-1:0];
      s2_fix = s2_rem >= REM2_W'(DAYS_PER_MONTH);
      s2_k_in = s1_q_ff + KQ_W'(s2_fix);
      s2_r_in = s2_fix ? DREM_W'(s2_rem - REM2_W'(DAYS_PER_MONTH)) : s2_rem[DREM_W-1:0];
   end

   always_comb begin
      // Days left over are the remainder plus one, from 1 to 30.
      s3_dval = DY_W'(s2_r_ff) + DY_W'(1);
      if (!s2_dnz_ff) begin
         s3_days_in = '0;
      end else if (s2_dneg_ff) begin
         s3_days_in = -$signed(s3_dval);
      end else begin
         s3_days_in = $signed(s3_dval);
      end
      // Nonzero months always share the sign of nonzero days here, so the
      // carry adds to the month magnitude.
      s3_mabs    = s2_mo_ff[IN_W-1] ? -s2_mo_ff : s2_mo_ff;
      s3_mmag_in = MMAG_W'(s3_mabs) + (s2_dnz_ff ? MMAG_W'(s2_k_ff) : MMAG_W'(0));
      s3_mneg_in = s2_dnz_ff ? s2_dneg_ff : s2_mo_ff[IN_W-1];
   end

   always_comb begin
      s4_prod = MPROD_W'(s3_mmag_ff[MMAG_W-1:2]) * MPROD_W'(MQ_RECIP);
      s4_q_in = s4_prod[MQ_RECIP_SHIFT +: MQ_W];
   end

   always_comb begin
      s5_sub = s4_mmag_ff - MMAG_W'(s4_q_ff) * MMAG_W'(MONTHS_PER_YEAR);
      s5_rem = s5_sub[DREM_W-1:0];
      s5_fix = s5_rem >= DREM_W'(MONTHS_PER_YEAR);
      s5_q   = s4_q_ff + MQ_W'(s5_fix);
      s5_r   = s5_fix ? MREM_W'(s5_rem - DREM_W'(MONTHS_PER_YEAR)) : s5_rem[MREM_W-1:0];
      s5_qs  = $signed(YR_W'(s5_q));
      s5_yr_in = s4_mneg_ff ? YR_W'(s4_yr_ff) - s5_qs : YR_W'(s4_yr_ff) + s5_qs;
      s5_mo_in = s4_mneg_ff ? -$signed(MO_W'(s5_r)) : $signed(MO_W'(s5_r));
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_dm1_ff  <= s1_dm1_in;
         s1_q_ff    <= s1_q_in;
         s1_dnz_ff  <= dmag_in != '0;
         s1_dneg_ff <= dneg_in;
         s1_mo_ff   <= mo_in;
         s1_yr_ff   <= yr_in;
      end
      if (adv[1]) begin
         s2_k_ff    <= s2_k_in;
         s2_r_ff    <= s2_r_in;
         s2_dnz_ff  <= s1_dnz_ff;
         s2_dneg_ff <= s1_dneg_ff;
         s2_mo_ff   <= s1_mo_ff;
         s2_yr_ff   <= s1_yr_ff;
      end
      if (adv[2]) begin
         s3_days_ff <= s3_days_in;
         s3_mmag_ff <= s3_mmag_in;
         s3_mneg_ff <= s3_mneg_in;
         s3_yr_ff   <= s2_yr_ff;
      end
      if (adv[3]) begin
         s4_q_ff    <= s4_q_in;
         s4_mmag_ff <= s3_mmag_ff;
         s4_mneg_ff <= s3_mneg_ff;
         s4_days_ff <= s3_days_ff;
         s4_yr_ff   <= s3_yr_ff;
      end
      if (adv[4]) begin
         s5_yr_ff   <= s5_yr_in;
         s5_mo_ff   <= s5_mo_in;
         s5_days_ff <= s4_days_ff;
      end
   end

   assign years  = s5_yr_ff;
   assign months = s5_mo_ff;
   assign days   = s5_days_ff;

endmodule

[src/inr_clock_split.sv]
`timescale 1ns / 1ps
// ============================================================================
// inr_clock_split
// Splits the magnitude of the remaining time into hours, minutes and
// seconds, in step with the day and month carry.
// ============================================================================
module inr_clock_split (
   input  logic                             clock,
   input  logic [4:0]                       adv,
   input  logic signed [inr_pkg::TS_W-1:0]  t_in,
   output logic signed [inr_pkg::TS_W-1:0]  time_seconds,
   output logic [inr_pkg::TH_W-1:0]         time_hours,
   output logic [inr_pkg::TM_W-1:0]         time_minutes,
   output logic [inr_pkg::TSEC_W-1:0]       time_secs
);
   import inr_pkg::*;

   localparam int TPROD_W = TABS_W - 2 + TQ_RECIP_W;

   // Stage 1: magnitude and whole minutes.
   logic [TS_W-1:0]        s1_abs;
   logic [TABS_W-1:0]      s1_at_in, s1_at_ff;
   logic [TPROD_W-1:0]     s1_prod;
   logic [MT_W-1:0]        s1_mt_in, s1_mt_ff;
   logic signed [TS_W-1:0] s1_t_ff;

   // Stage 2: seconds and whole hours.
   logic [TABS_W-1:0]      s2_sub;
   logic [TPROD_W-1:0]     s2_prod;
   logic [TSEC_W-1:0]      s2_secs_in, s2_secs_ff;
   logic [TH_W-1:0]        s2_hrs_in, s2_hrs_ff;
   logic [MT_W-1:0]        s2_mt_ff;
   logic signed [TS_W-1:0] s2_t_ff;

   // Stage 3: minutes within the hour.
   logic [MT_W-1:0]        s3_sub;
   logic [TM_W-1:0]        s3_min_in, s3_min_ff;
   logic [TSEC_W-1:0]      s3_secs_ff;
   logic [TH_W-1:0]        s3_hrs_ff;
   logic signed [TS_W-1:0] s3_t_ff;

   // Stages 4 and 5 keep the fields aligned with the month carry.
   logic [TM_W-1:0]        s4_min_ff, s5_min_ff;
   logic [TSEC_W-1:0]      s4_secs_ff, s5_secs_ff;
   logic [TH_W-1:0]        s4_hrs_ff, s5_hrs_ff;
   logic signed [TS_W-1:0] s4_t_ff, s5_t_ff;

   always_comb begin
      s1_abs   = t_in[TS_W-1] ? -t_in : t_in;
      s1_at_in = s1_abs[TABS_W-1:0];
      s1_prod  = TPROD_W'(s1_at_in[TABS_W-1:2]) * TPROD_W'(TQ_RECIP);
      s1_mt_in = s1_prod[TQ_SHIFT +: MT_W];
   end

   always_comb begin
      s2_sub     = s1_at_ff - TABS_W'(s1_mt_ff) * TABS_W'(SECS_PER_MIN);
      s2_secs_in = s2_sub[TSEC_W-1:0];
      s2_prod    = TPROD_W'(s1_mt_ff[MT_W-1:2]) * TPROD_W'(TQ_RECIP);
      s2_hrs_in  = s2_prod[TQ_SHIFT +: TH_W];
   end

   always_comb begin
      s3_sub    = s2_mt_ff - MT_W'(s2_hrs_ff) * MT_W'(SECS_PER_MIN);
      s3_min_in = s3_sub[TM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_at_ff <= s1_at_in;
         s1_mt_ff <= s1_mt_in;
         s1_t_ff  <= t_in;
      end
      if (adv[1]) begin
         s2_secs_ff <= s2_secs_in;
         s2_hrs_ff  <= s2_hrs_in;
         s2_mt_ff   <= s1_mt_ff;
         s2_t_ff    <= s1_t_ff;
      end
      if (adv[2]) begin
         s3_min_ff  <= s3_min_in;
         s3_secs_ff <= s2_secs_ff;
         s3_hrs_ff  <= s2_hrs_ff;
         s3_t_ff    <= s2_t_ff;
      end
      if (adv[3]) begin
         s4_min_ff  <= s3_min_ff;
         s4_secs_ff <= s3_secs_ff;
         s4_hrs_ff  <= s3_hrs_ff;
         s4_t_ff    <= s3_t_ff;
      end
      if (adv[4]) begin
         s5_min_ff  <= s4_min_ff;
         s5_secs_ff <= s4_secs_ff;
         s5_hrs_ff  <= s4_hrs_ff;
         s5_t_ff    <= s4_t_ff;
      end
   end

   assign time_seconds = s5_t_ff;
   assign time_hours   = s5_hrs_ff;
   assign time_minutes = s5_min_ff;
   assign time_secs    = s5_secs_ff;

endmodule

[src/interval_normalizer_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// interval_normalizer_top
// Puts a signed interval of years, months, weeks, days, hours, minutes and
// seconds into justified form: years, months, days and time of day.
// ============================================================================
// Usage:
//   The request channel carries one interval per beat (req_valid, req_stall);
//   the response channel returns exactly one normalized interval per request
//   beat, in order (rsp_valid, rsp_stall).
//   A request beat passes through the registers of the day split, the sign
//   merge and then the carry and clock split before its response beat shows
//   on rsp_valid. Throughput is one beat per cycle while rsp_stall is low;
//   the ten pipeline registers with their valid bits set it.
//   Each stage holds its beat while the stage after it is full and stalled,
//   and empty stages keep filling, so up to ten beats wait inside before
//   req_stall rises. A beat is neither lost nor repeated under any stall
//   pattern.
//   Synchronous reset clears every valid bit; the pipeline is then empty and
//   takes a request beat in the next cycle. There are no configuration
//   registers and no state is kept from one interval to the next.
// ============================================================================
module interval_normalizer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  inr_pkg::field_type               req_years_in,
   input  inr_pkg::field_type               req_months_in,
   input  inr_pkg::field_type               req_weeks_in,
   input  inr_pkg::field_type               req_days_in,
   input  inr_pkg::field_type               req_hours_in,
   input  inr_pkg::field_type               req_minutes_in,
   input  inr_pkg::field_type               req_seconds_in,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [inr_pkg::YR_W-1:0]  rsp_years,
   output logic signed [inr_pkg::MO_W-1:0]  rsp_months,
   output logic signed [inr_pkg::DY_W-1:0]  rsp_days,
   output logic signed [inr_pkg::TS_W-1:0]  rsp_time_seconds,
   output logic [inr_pkg::TH_W-1:0]         rsp_time_hours,
   output logic [inr_pkg::TM_W-1:0]         rsp_time_minutes,
   output logic [inr_pkg::TSEC_W-1:0]       rsp_time_secs
);
   import inr_pkg::*;

   logic [NSTAGE-1:0] vld_in, vld_ff;
   logic [NSTAGE:0]   rdy;

   logic signed [TS_W-1:0]   sp_t;
   logic signed [DSUM_W-1:0] sp_dy;
   field_type                sp_mo, sp_yr;
   logic signed [TS_W-1:0]   mg_t;
   logic [DMAG_W-1:0]        mg_dmag;
   logic                     mg_dneg;
   field_type                mg_mo, mg_yr;

   // A stage takes a new beat when it is empty or its content moves on.
   assign rdy[NSTAGE] = !rsp_stall;
   genvar g;
   for (g = 0; g < NSTAGE; g++) begin : g_rdy
      assign rdy[g] = !vld_ff[g] || rdy[g+1];
   end

   assign vld_in = {vld_ff[NSTAGE-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= (vld_ff & ~rdy[NSTAGE-1:0]) | (vld_in & rdy[NSTAGE-1:0]);
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[NSTAGE-1];

   inr_day_split u_day_split (
      .clock      (clock),
      .adv        (rdy[STG_MERGE-1:0]),
      .years_in   (req_years_in),
      .months_in  (req_months_in),
      .weeks_in   (req_weeks_in),
      .days_in    (req_days_in),
      .hours_in   (req_hours_in),
      .minutes_in (req_minutes_in),
      .seconds_in (req_seconds_in),
      .t_out      (sp_t),
      .dy_out     (sp_dy),
      .mo_out     (sp_mo),
      .yr_out     (sp_yr)
   );

   inr_sign_merge u_sign_merge (
      .clock    (clock),
      .adv      (rdy[STG_CARRY-1:STG_MERGE]),
      .t_in     (sp_t),
      .dy_in    (sp_dy),
      .mo_in    (sp_mo),
      .yr_in    (sp_yr),
      .t_out    (mg_t),
      .dmag_out (mg_dmag),
      .dneg_out (mg_dneg),
      .mo_out   (mg_mo),
      .yr_out   (mg_yr)
   );

   inr_carry u_carry (
      .clock   (clock),
      .adv     (rdy[NSTAGE-1:STG_CARRY]),
      .dmag_in (mg_dmag),
      .dneg_in (mg_dneg),
      .mo_in   (mg_mo),
      .yr_in   (mg_yr),
      .years   (rsp_years),
      .months  (rsp_months),
      .days    (rsp_days)
   );

   inr_clock_split u_clock_split (
      .clock        (clock),
      .adv          (rdy[NSTAGE-1:STG_CARRY]),
      .t_in         (mg_t),
      .time_seconds (rsp_time_seconds),
      .time_hours   (rsp_time_hours),
      .time_minutes (rsp_time_minutes),
      .time_secs    (rsp_time_secs)
   );

endmodule
